// ===== hw/rtl/sppc_pkg.sv =====
// Shared types and constants for the sphere pair contact phase block.
package sppc_pkg;

    localparam int PAIR_DEPTH = 1024;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;
    localparam int DIV_W      = 33 + 14;

    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_ENTER = 2'd1;
    localparam logic [1:0] PHASE_STAY  = 2'd2;
    localparam logic [1:0] PHASE_EXIT  = 2'd3;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic [30:0]        a_radius;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic [30:0]        b_radius;
        logic [9:0]         pair_index;
        logic               a_is_trigger;
        logic               b_is_trigger;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [1:0]         phase;
        logic               trigger_pair;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [31:0]        penetration;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
        logic signed [31:0] push_z;
    } t_rsp;

    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][32:0]     mag;
        logic [31:0]          rsum;
        logic [PAIR_AW-1:0]   idx;
        logic                 trig;
    } t_geo;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][32:0] mag;
        logic [31:0]      rsum;
        logic             hit;
        logic [1:0]       phase;
        logic             trig;
    } t_ctx;

endpackage

// ===== hw/rtl/sppc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sppc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sphere_pair_contact_phase.sv =====
// Pipelined sphere pair overlap test with normal, depth, push and contact phase.
//
// Requests arrive on i_req_valid / o_req_ready with one collider pair in i_req.
// Each request yields exactly one response on o_rsp_valid / i_rsp_ready in o_rsp.
// The pipeline accepts one request per cycle while not stalled or clearing, and
// computes each response through stages of difference, squaring and summing,
// 33 stages of a one-bit-per-stage square root, 16 stages of a one-bit-per-stage
// divider for the normal, then the depth product and the rounded, saturated push.
// The per-pair touching bits live in a 1024 x 1 RAM that is read and updated
// in stage five; back-to-back requests on the same pair are forwarded.
// After reset the block clears the touching RAM, one entry per cycle, and
// holds o_req_ready low until every entry is cleared.
// When the receiver stalls, the whole pipeline holds and o_req_ready falls in
// the same cycle; no request is dropped or repeated.
module sphere_pair_contact_phase (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  sppc_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output sppc_pkg::t_rsp  o_rsp
);
    import sppc_pkg::*;

    logic w_adv;
    logic w_acc;

    logic               r_clr_busy;
    logic [PAIR_AW-1:0] r_clr_addr;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    t_geo        r_geo1, r_geo2, r_geo3, r_geo4, r_geo5;
    logic [33:0] r_hh2 [3];
    logic [32:0] r_hl2 [3];
    logic [31:0] r_ll2 [3];
    logic [31:0] r_rhh2, r_rhl2, r_rll2;
    logic [65:0] r_sq3 [3];
    logic [63:0] r_rr3;
    logic [65:0] r_s4;
    logic [63:0] r_rr4;
    logic [63:0] r_s5;
    logic        r_hit5;

    logic               r_sq_v   [SQRT_STEPS+1];
    t_ctx               r_sq_ctx [SQRT_STEPS+1];
    logic [63:0]        r_sq_n   [SQRT_STEPS+1];
    logic [63:0]        r_sq_r   [SQRT_STEPS+1];
    logic [PAIR_AW-1:0] r_idx6;

    logic                 r_dv_v   [DIV_STEPS+1];
    t_ctx                 r_dv_ctx [DIV_STEPS+1];
    logic [31:0]          r_dv_den [DIV_STEPS+1];
    logic [31:0]          r_dv_pen [DIV_STEPS+1];
    logic [2:0][DIV_W-1:0]     r_dv_rem [DIV_STEPS+1];
    logic [2:0][DIV_STEPS-1:0] r_dv_q   [DIV_STEPS+1];

    logic                 r_vn;
    logic [15:0]          r_nrm_n [3];
    logic [DIV_STEPS-1:0] r_qm_n  [3];
    logic [2:0]           r_neg_n;
    logic [31:0]          r_pen_n;
    logic                 r_hit_n, r_trig_n;
    logic [1:0]           r_phase_n;

    logic        r_vp;
    logic [46:0] r_prod_p [3];
    logic [15:0] r_nrm_p  [3];
    logic [2:0]  r_neg_p;
    logic [31:0] r_pen_p;
    logic        r_hit_p, r_trig_p;
    logic [1:0]  r_phase_p;

    logic r_out_v;
    t_rsp r_out;
    t_rsp n_out;

    logic [31:0] w_ax [3];
    logic [31:0] w_bx [3];
    logic [32:0] w_dba [3];
    logic [32:0] w_dab [3];
    t_geo        w_geo1;

    logic               w_ram_q;
    logic               w_prev;
    logic [1:0]         w_phase5;
    logic               w_tbl_we;
    logic               w_ram_we;
    logic [PAIR_AW-1:0] w_ram_waddr;
    logic               w_ram_wdata;
    t_ctx               w_ctx6;

    logic [31:0]          w_dist;
    logic                 w_nz;
    logic [46:0]          w_prod [3];
    logic [46:0]          w_rnd  [3];
    logic [31:0]          w_pmag [3];
    logic [31:0]          w_push [3];

    assign w_adv       = !r_out_v || i_rsp_ready;
    assign o_req_ready = w_adv && !r_clr_busy;
    assign w_acc       = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == PAIR_AW'(PAIR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Stage 1: signed differences, their magnitudes and the radius sum.
    assign w_ax[0] = i_req.a_x;
    assign w_ax[1] = i_req.a_y;
    assign w_ax[2] = i_req.a_z;
    assign w_bx[0] = i_req.b_x;
    assign w_bx[1] = i_req.b_y;
    assign w_bx[2] = i_req.b_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dba[a] = {w_bx[a][31], w_bx[a]} - {w_ax[a][31], w_ax[a]};
            w_dab[a] = {w_ax[a][31], w_ax[a]} - {w_bx[a][31], w_bx[a]};
            w_geo1.neg[a] = w_dba[a][32];
            w_geo1.mag[a] = w_dba[a][32] ? w_dab[a] : w_dba[a];
        end
        w_geo1.rsum = {1'b0, i_req.a_radius} + {1'b0, i_req.b_radius};
        w_geo1.idx  = i_req.pair_index;
        w_geo1.trig = i_req.a_is_trigger | i_req.b_is_trigger;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_geo1 <= w_geo1;
            r_geo2 <= r_geo1;
            r_geo3 <= r_geo2;
            r_geo4 <= r_geo3;
            r_geo5 <= r_geo4;
            for (int a = 0; a < 3; a++) begin
                r_hh2[a] <= r_geo1.mag[a][32:16] * r_geo1.mag[a][32:16];
                r_hl2[a] <= r_geo1.mag[a][32:16] * r_geo1.mag[a][15:0];
                r_ll2[a] <= r_geo1.mag[a][15:0] * r_geo1.mag[a][15:0];
                r_sq3[a] <= {r_hh2[a], 32'd0} + {16'd0, r_hl2[a], 17'd0}
                            + {34'd0, r_ll2[a]};
            end
            r_rhh2 <= r_geo1.rsum[31:16] * r_geo1.rsum[31:16];
            r_rhl2 <= r_geo1.rsum[31:16] * r_geo1.rsum[15:0];
            r_rll2 <= r_geo1.rsum[15:0] * r_geo1.rsum[15:0];
            r_rr3  <= {r_rhh2, 32'd0} + {15'd0, r_rhl2, 17'd0} + {32'd0, r_rll2};
            r_s4   <= r_sq3[0] + r_sq3[1] + r_sq3[2];
            r_rr4  <= r_rr3;
            r_s5   <= r_s4[63:0];
            r_hit5 <= r_s4 <= {2'b00, r_rr4};
        end
    end

    // Stage 5: touching bit lookup, forwarded from the next stage on a repeat pair.
    assign w_prev = (r_sq_v[0] && r_idx6 == r_geo5.idx) ? r_sq_ctx[0].hit : w_ram_q;

    always_comb begin
        if (r_hit5 == w_prev) begin
            w_phase5 = w_prev ? PHASE_STAY : PHASE_NONE;
        end else begin
            w_phase5 = w_prev ? PHASE_EXIT : PHASE_ENTER;
        end
    end

    assign w_tbl_we    = w_adv && r_v5 && (r_hit5 != w_prev);
    assign w_ram_we    = r_clr_busy || w_tbl_we;
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : r_geo5.idx;
    assign w_ram_wdata = !r_clr_busy && r_hit5;

    sppc_ram #(
        .WIDTH(1),
        .DEPTH(PAIR_DEPTH)
    ) u_touch_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_adv),
        .i_raddr(r_geo4.idx),
        .o_rdata(w_ram_q)
    );

    always_comb begin
        w_ctx6.neg   = r_geo5.neg;
        w_ctx6.mag   = r_geo5.mag;
        w_ctx6.rsum  = r_geo5.rsum;
        w_ctx6.hit   = r_hit5;
        w_ctx6.phase = w_phase5;
        w_ctx6.trig  = r_geo5.trig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_v[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_ctx[0] <= w_ctx6;
            r_sq_n[0]   <= r_s5;
            r_sq_r[0]   <= '0;
            r_idx6      <= r_geo5.idx;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [63:0] w_bit;
        logic [63:0] w_try;
        logic        w_take;

        assign w_bit  = 64'd1 << (62 - 2 * k);
        assign w_try  = r_sq_r[k] + w_bit;
        assign w_take = r_sq_n[k] >= w_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_ctx[k+1] <= r_sq_ctx[k];
                r_sq_n[k+1]   <= w_take ? r_sq_n[k] - w_try : r_sq_n[k];
                r_sq_r[k+1]   <= w_take ? (r_sq_r[k] >> 1) + w_bit : r_sq_r[k] >> 1;
            end
        end
    end

    assign w_dist = r_sq_r[SQRT_STEPS][31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= r_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_ctx[0] <= r_sq_ctx[SQRT_STEPS];
            r_dv_den[0] <= w_dist;
            r_dv_pen[0] <= r_sq_ctx[SQRT_STEPS].rsum - w_dist;
            for (int a = 0; a < 3; a++) begin
                r_dv_rem[0][a] <= {r_sq_ctx[SQRT_STEPS].mag[a], 14'd0}
                                  + {16'd0, w_dist[31:1]};
                r_dv_q[0][a]   <= '0;
            end
        end
    end

    // Rounded normal division, one quotient bit per stage on all three axes.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DIV_W-1:0] w_dsh;

        assign w_dsh = {15'd0, r_dv_den[k]} << (DIV_STEPS - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_ctx[k+1] <= r_dv_ctx[k];
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_pen[k+1] <= r_dv_pen[k];
                for (int a = 0; a < 3; a++) begin
                    if (r_dv_rem[k][a] >= w_dsh) begin
                        r_dv_rem[k+1][a] <= r_dv_rem[k][a] - w_dsh;
                        r_dv_q[k+1][a]   <= r_dv_q[k][a]
                                            | (DIV_STEPS'(1) << (DIV_STEPS - 1 - k));
                    end else begin
                        r_dv_rem[k+1][a] <= r_dv_rem[k][a];
                        r_dv_q[k+1][a]   <= r_dv_q[k][a];
                    end
                end
            end
        end
    end

    assign w_nz = r_dv_ctx[DIV_STEPS].hit && (r_dv_den[DIV_STEPS] != '0);

    for (genvar a = 0; a < 3; a++) begin : g_push
        assign w_prod[a] = r_qm_n[a] * r_pen_n;
        assign w_rnd[a]  = r_prod_p[a] + 47'd16384;
        assign w_pmag[a] = w_rnd[a][46:15];
        assign w_push[a] = r_trig_p ? 32'd0
                         : r_neg_p[a] ? 32'd0 - w_pmag[a]
                         : w_pmag[a][31] ? 32'h7FFF_FFFF : w_pmag[a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn    <= 1'b0;
            r_vp    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_vn    <= r_dv_v[DIV_STEPS];
            r_vp    <= r_vn;
            r_out_v <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_qm_n[a]  <= w_nz ? r_dv_q[DIV_STEPS][a] : '0;
                r_nrm_n[a] <= !w_nz ? 16'd0
                            : r_dv_ctx[DIV_STEPS].neg[a]
                              ? 16'd0 - {1'b0, r_dv_q[DIV_STEPS][a]}
                              : {1'b0, r_dv_q[DIV_STEPS][a]};
                r_prod_p[a] <= w_prod[a];
                r_nrm_p[a]  <= r_nrm_n[a];
            end
            r_neg_n   <= r_dv_ctx[DIV_STEPS].neg;
            r_pen_n   <= r_dv_ctx[DIV_STEPS].hit ? r_dv_pen[DIV_STEPS] : 32'd0;
            r_hit_n   <= r_dv_ctx[DIV_STEPS].hit;
            r_trig_n  <= r_dv_ctx[DIV_STEPS].trig;
            r_phase_n <= r_dv_ctx[DIV_STEPS].phase;
            r_neg_p   <= r_neg_n;
            r_pen_p   <= r_pen_n;
            r_hit_p   <= r_hit_n;
            r_trig_p  <= r_trig_n;
            r_phase_p <= r_phase_n;
            r_out     <= n_out;
        end
    end

    always_comb begin
        n_out.hit          = r_hit_p;
        n_out.phase        = r_phase_p;
        n_out.trigger_pair = r_trig_p;
        n_out.normal_x     = r_nrm_p[0];
        n_out.normal_y     = r_nrm_p[1];
        n_out.normal_z     = r_nrm_p[2];
        n_out.penetration  = r_pen_p;
        n_out.push_x       = w_push[0];
        n_out.push_y       = w_push[1];
        n_out.push_z       = w_push[2];
    end

    assign o_rsp_valid = r_out_v;
    assign o_rsp       = r_out;

    a_phase_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.hit == (o_rsp.phase == PHASE_ENTER
                                       || o_rsp.phase == PHASE_STAY)))
        else $error("phase disagrees with hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.hit) |-> (o_rsp.penetration == 32'd0
            && o_rsp.normal_x == 16'sd0 && o_rsp.push_x == 32'sd0))
        else $error("miss with nonzero contact data");

    a_trig_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.trigger_pair) |-> (o_rsp.push_x == 32'sd0
            && o_rsp.push_y == 32'sd0 && o_rsp.push_z == 32'sd0))
        else $error("trigger pair with push");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.normal_x <= 16'sd16384 && o_rsp.normal_x >= -16'sd16384
            && o_rsp.normal_y <= 16'sd16384 && o_rsp.normal_y >= -16'sd16384))
        else $error("normal out of unit range");

endmodule

// ===== test/sphere_pair_contact_phase_tb.sv =====
// Testbench for sphere_pair_contact_phase: random and directed pairs against a predictor.
`timescale 1ns / 1ps

module sphere_pair_contact_phase_tb;

    import sppc_pkg::*;

    class contact_scoreboard;
        bit   touching [PAIR_DEPTH];
        t_rsp pending [$];
        int   errors;

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint div_nearest(longint num, longint unsigned den);
            longint unsigned m;
            longint unsigned q;
            m = (num < 0) ? longint'(-num) : longint'(num);
            q = (m + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function t_rsp predict_contact(t_req q);
            t_rsp            o;
            longint          d [3];
            longint          n [3];
            longint          p [3];
            longint          v;
            longint unsigned m;
            longint unsigned rsum;
            longint unsigned span;
            longint unsigned pen;
            logic [127:0]    s;
            bit              hit;
            bit              prev;
            bit              trig;
            d[0] = longint'(q.b_x) - longint'(q.a_x);
            d[1] = longint'(q.b_y) - longint'(q.a_y);
            d[2] = longint'(q.b_z) - longint'(q.a_z);
            rsum = longint'(q.a_radius) + longint'(q.b_radius);
            trig = q.a_is_trigger | q.b_is_trigger;
            s = '0;
            pen = 0;
            for (int i = 0; i < 3; i++) begin
                m = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
                s = s + 128'(m) * 128'(m);
                n[i] = 0;
                p[i] = 0;
            end
            hit = (s <= 128'(rsum) * 128'(rsum));
            if (hit) begin
                span = root_floor(s[63:0]);
                pen = rsum - span;
                if (span != 0) begin
                    for (int i = 0; i < 3; i++) n[i] = div_nearest(d[i] * 16384, span);
                end
                if (!trig) begin
                    for (int i = 0; i < 3; i++) begin
                        v = div_nearest(n[i] * longint'(pen), 32768);
                        if (v > 64'sd2147483647) v = 64'sd2147483647;
                        if (v < -64'sd2147483648) v = -64'sd2147483648;
                        p[i] = v;
                    end
                end
            end
            prev = touching[q.pair_index];
            if (hit == prev) begin
                o.phase = prev ? PHASE_STAY : PHASE_NONE;
            end else begin
                o.phase = prev ? PHASE_EXIT : PHASE_ENTER;
                touching[q.pair_index] = hit;
            end
            o.hit = hit;
            o.trigger_pair = trig;
            o.normal_x = n[0][15:0];
            o.normal_y = n[1][15:0];
            o.normal_z = n[2][15:0];
            o.penetration = pen[31:0];
            o.push_x = p[0][31:0];
            o.push_y = p[1][31:0];
            o.push_z = p[2][31:0];
            return o;
        endfunction

        function void note_request(t_req q);
            pending.push_back(predict_contact(q));
        endfunction

        function void compare_field(string f, longint e, longint a);
            if (e != a) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %0h, got %0h", f, e, a);
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("response with no request outstanding");
                return;
            end
            e = pending.pop_front();
            compare_field("hit", e.hit, got.hit);
            compare_field("phase", e.phase, got.phase);
            compare_field("trigger_pair", e.trigger_pair, got.trigger_pair);
            compare_field("normal_x", e.normal_x, got.normal_x);
            compare_field("normal_y", e.normal_y, got.normal_y);
            compare_field("normal_z", e.normal_z, got.normal_z);
            compare_field("penetration", e.penetration, got.penetration);
            compare_field("push_x", e.push_x, got.push_x);
            compare_field("push_y", e.push_y, got.push_y);
            compare_field("push_z", e.push_z, got.push_z);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    contact_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles = 0;

    sphere_pair_contact_phase i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_rsp_ready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
        if ((o_rsp_valid && i_rsp_ready) || (i_req_valid && o_req_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pair(t_req q);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_valid = 1'b1;
        i_req = q;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(q);
    endtask

    task automatic drain_responses();
        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req make_pair(int kind);
        t_req         q;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        q = raw[$bits(t_req)-1:0];
        if (kind < 70) begin
            q.a_x = $signed($urandom_range(2097152)) - 1048576;
            q.a_y = $signed($urandom_range(2097152)) - 1048576;
            q.a_z = $signed($urandom_range(2097152)) - 1048576;
            q.b_x = q.a_x + $signed($urandom_range(524288)) - 262144;
            q.b_y = q.a_y + $signed($urandom_range(524288)) - 262144;
            q.b_z = q.a_z + $signed($urandom_range(524288)) - 262144;
            q.a_radius = 31'($urandom_range(262144));
            q.b_radius = 31'($urandom_range(262144));
            q.pair_index = 10'($urandom_range(15));
        end else if (kind < 78) begin
            q.b_x = q.a_x;
            q.b_y = q.a_y;
            q.b_z = q.a_z;
            q.pair_index = 10'($urandom_range(15));
        end else if (kind < 86) begin
            q.a_radius = 31'(32'h7fffffff - $urandom_range(65535));
            q.b_radius = 31'(32'h7fffffff - $urandom_range(65535));
            q.b_x = q.a_x + $signed($urandom_range(4096)) - 2048;
            q.b_y = q.a_y;
            q.b_z = q.a_z;
        end
        return q;
    endfunction

    function automatic t_req place_pair(int ax, int bx, int ra, int rb, int idx, bit ta,
                                        bit tb);
        t_req q;
        q = '0;
        q.a_x = ax;
        q.b_x = bx;
        q.a_radius = 31'(ra);
        q.b_radius = 31'(rb);
        q.pair_index = 10'(idx);
        q.a_is_trigger = ta;
        q.b_is_trigger = tb;
        return q;
    endfunction

    initial begin
        t_req q;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_pair(place_pair(0, 0, 65536, 65536, 3, 0, 0));
        send_pair(place_pair(0, 65536, 65536, 65536, 3, 0, 0));
        send_pair(place_pair(0, 131072, 65536, 65536, 3, 0, 0));
        send_pair(place_pair(0, 131073, 65536, 65536, 3, 0, 0));
        send_pair(place_pair(0, 131073, 65536, 65536, 3, 0, 0));
        send_pair(place_pair(0, 1000, 65536, 0, 1023, 1, 0));
        send_pair(place_pair(0, -1000, 0, 65536, 1023, 0, 1));
        send_pair(place_pair(0, 1, 31'h7fffffff, 31'h7fffffff, 0, 0, 0));
        send_pair(place_pair(1, 0, 31'h7fffffff, 31'h7fffffff, 0, 0, 0));
        send_pair(place_pair(5, 5, 31'h7fffffff, 31'h7fffffff, 512, 1, 1));
        q = place_pair(32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff, 1, 0, 0);
        q.a_y = 32'sh80000000;
        q.a_z = 32'sh80000000;
        q.b_y = 32'sh7fffffff;
        q.b_z = 32'sh7fffffff;
        send_pair(q);
        q = '1;
        q.a_is_trigger = 1'b0;
        send_pair(q);
        q = place_pair(0, 0, 0, 0, 7, 0, 0);
        q.b_y = 300000;
        q.b_z = -300000;
        q.a_radius = 400000;
        send_pair(q);
        drain_responses();

        send_idle_pct = 21;
        recv_idle_pct = 69;
        rx_hold_cycles = 300;
        repeat (380) send_pair(make_pair($urandom_range(99)));
        drain_responses();

        send_idle_pct = 69;
        recv_idle_pct = 21;
        repeat (380) send_pair(make_pair($urandom_range(99)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (380) send_pair(make_pair($urandom_range(99)));
        drain_responses();
        repeat (100) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
